// ----- rtl/twtb_pkg.sv -----
// shared constants, types and helpers of the time window trend buffer
package twtb_pkg;

	localparam int MAX_ROWS = 1024;
	localparam int MAX_COLS = 8;
	localparam int MIN_ROWS = 16;

	localparam int ROW_AW   = $clog2(MAX_ROWS);
	localparam int CNT_W    = $clog2(MAX_ROWS + 1);
	localparam int COL_W    = $clog2(MAX_COLS + 1);
	localparam int VAW      = $clog2(MAX_ROWS * MAX_COLS);
	localparam int TIME_W   = 48;
	localparam int VAL_W    = 32;
	localparam int FRAC_W   = 8;
	localparam int POS_W    = 18;
	localparam int RAT_W    = 16;
	localparam int RSEL_W   = 10;
	localparam int CSEL_W   = 3;
	localparam int HOLD_W   = 11;
	localparam int NCOL_W   = 4;

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_COLUMN = 2'd1,
		CMD_FIND   = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	localparam logic [ROW_AW:0] ROWS_EXT = (ROW_AW + 1)'(MAX_ROWS);

	// ring position of logical row r
	function automatic logic [ROW_AW-1:0] phys_row(input logic [ROW_AW-1:0] base,
			input logic [ROW_AW-1:0] r);
		logic [ROW_AW:0] s;
		s = {1'b0, base} + {1'b0, r};
		if (s >= ROWS_EXT) begin
			s = s - ROWS_EXT;
		end
		return s[ROW_AW-1:0];
	endfunction

endpackage

// ----- rtl/twtb_if.sv -----
// request and result channel interfaces
interface twtb_in_if import twtb_pkg::*;;
	logic                valid;
	logic                ready;
	cmd_t                command;
	logic [TIME_W-1:0]   x_value;
	logic signed [VAL_W-1:0] y_value;
	logic [NCOL_W-1:0]   column_count;
	logic [RSEL_W-1:0]   row_select;
	logic [CSEL_W-1:0]   col_select;

	modport source (output valid, command, x_value, y_value, column_count, row_select,
		col_select, input ready);
	modport sink (input valid, command, x_value, y_value, column_count, row_select,
		col_select, output ready);
endinterface

interface twtb_out_if import twtb_pkg::*;;
	logic                valid;
	logic                ready;
	logic                ok;
	logic [TIME_W-1:0]   time_out;
	logic signed [VAL_W-1:0] value_out;
	logic [POS_W-1:0]    row_position;
	logic [HOLD_W-1:0]   rows_held;
	logic [NCOL_W-1:0]   cols_held;

	modport source (output valid, ok, time_out, value_out, row_position, rows_held,
		cols_held, input ready);
	modport sink (input valid, ok, time_out, value_out, row_position, rows_held,
		cols_held, output ready);
endinterface

// ----- rtl/twtb_ram.sv -----
// generic simple dual port ram with registered read
module twtb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/twtb_div.sv -----
// restoring divider for the search ratio, one quotient bit per cycle
module twtb_div import twtb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] num,
	input  logic [TIME_W-1:0] den,
	output logic              done,
	output logic [RAT_W-1:0]  quo
);
	localparam int CW = $clog2(RAT_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] den_q;
	logic [RAT_W-1:0]  quo_q;
	logic [TIME_W:0]   shifted;

	assign shifted = {rem_q, 1'b0};
	assign done    = done_q;
	assign quo     = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RAT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (shifted >= {1'b0, den_q}) begin
				rem_q <= TIME_W'(shifted - {1'b0, den_q});
				quo_q <= {quo_q[RAT_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[TIME_W-1:0];
				quo_q <= {quo_q[RAT_W-2:0], 1'b0};
			end
		end
	end
endmodule

// ----- rtl/time_window_trend_buffer_top.sv -----
// time window trend buffer: ring of trend rows, cell reads and interpolation search
//
// requests arrive on req (valid/ready); each request gives exactly one result on rsp.
// start row (command 0) stores the row time; column values (command 1) fill the row,
// the last one completes it and retires old rows outside window_span down to MIN_ROWS.
// find (command 2) returns a fractional row index, read (command 3) one cell.
// one request is worked at a time; req.ready is high while the sequencer is idle.
// working states of each request, in order, before the closing FIN state:
//   start: START, FULL, FULLW on a full ring (drops the oldest row), WTIME,
//   then COMPLETE and RETIRE for a row with no columns; column: COL, then COMPLETE
//   and RETIRE when it completes the row; read: RDW, none when out of range;
//   RETIRE and RETW repeat per retired row; find: FCHK, done there without
//   interpolation, else per step FDIV (ratio divider), FGUESS, FISSUE, FPROBE
//   (one time ram read), ending early on a probe that hits the time exactly.
// FIN places the result in an output register; while the receiver stalls, the next
// request is still taken and worked, then waits until the register frees up.
// asynchronous reset empties the buffer and clears window_span; the row memories need
// no clearing pass, as only written entries are ever read.
// cfg_we writes window_span from cfg_wdata; write it only while the block is idle.
module time_window_trend_buffer_top import twtb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [TIME_W-1:0] cfg_wdata,
	twtb_in_if.sink           req,
	twtb_out_if.source        rsp
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_START, ST_FULL, ST_FULLW, ST_WTIME, ST_COL, ST_COMPLETE, ST_RETIRE,
		ST_RETW, ST_FCHK, ST_FDIV, ST_FGUESS, ST_FISSUE, ST_FPROBE, ST_RDW, ST_FIN
	} state_t;

	localparam int PROD_W = ROW_AW + RAT_W;

	state_t state_q;

	logic [TIME_W-1:0] window_span_q;
	logic [ROW_AW-1:0] oldest_q;
	logic [CNT_W-1:0]  count_q;
	logic [COL_W-1:0]  cols_q;
	logic [COL_W-1:0]  pend_q;
	logic [TIME_W-1:0] epoch_q;
	logic [TIME_W-1:0] newest_q;
	logic [TIME_W-1:0] oldest_rel_q;
	logic [TIME_W-1:0] cur_rel_q;

	logic [TIME_W-1:0] x_q;
	logic [VAL_W-1:0]  y_q;
	logic [COL_W-1:0]  nc_q;

	logic [TIME_W-1:0] xr_q;
	logic [ROW_AW-1:0] low_q;
	logic [ROW_AW-1:0] high_q;
	logic [TIME_W-1:0] low_v_q;
	logic [TIME_W-1:0] high_v_q;
	logic [POS_W-1:0]  guess_q;
	logic [ROW_AW-1:0] gi_q;

	logic              res_ok_q;
	logic [TIME_W-1:0] res_time_q;
	logic [VAL_W-1:0]  res_val_q;
	logic [POS_W-1:0]  res_pos_q;

	logic              rsp_valid_q;
	logic              rsp_ok_q;
	logic [TIME_W-1:0] rsp_time_q;
	logic [VAL_W-1:0]  rsp_val_q;
	logic [POS_W-1:0]  rsp_pos_q;
	logic [HOLD_W-1:0] rsp_rows_q;
	logic [NCOL_W-1:0] rsp_cols_q;

	logic              t_we;
	logic [ROW_AW-1:0] t_waddr;
	logic [TIME_W-1:0] t_wdata;
	logic [ROW_AW-1:0] t_raddr;
	logic [TIME_W-1:0] t_rdata;
	logic              v_we;
	logic [VAW-1:0]    v_waddr;
	logic [VAW-1:0]    v_raddr;
	logic [VAL_W-1:0]  v_rdata;

	logic              div_start;
	logic              div_done;
	logic [RAT_W-1:0]  div_quo;

	logic              req_acc;
	logic [COL_W-1:0]  nc_clamp;
	logic [ROW_AW-1:0] oldest_inc;
	logic [ROW_AW-1:0] wr_row;
	logic [ROW_AW-1:0] rd_row;
	logic              rd_in_range;
	logic              start_clear;
	logic              retire_go;
	logic [ROW_AW-1:0] span;
	logic [PROD_W-1:0] prod;
	logic [POS_W-1:0]  guess_next;
	logic [POS_W:0]    guess_rnd;
	logic [ROW_AW:0]   gi_raw;
	logic [ROW_AW-1:0] gi_next;
	logic              rsp_free;

	assign req_acc    = req.valid && req.ready;
	assign req.ready  = (state_q == ST_IDLE);
	assign nc_clamp   = (req.column_count > NCOL_W'(MAX_COLS)) ? COL_W'(MAX_COLS)
		: COL_W'(req.column_count);
	assign oldest_inc = (oldest_q == ROW_AW'(MAX_ROWS - 1)) ? '0 : oldest_q + 1'b1;
	assign wr_row     = phys_row(oldest_q, count_q[ROW_AW-1:0]);
	assign rd_row     = phys_row(oldest_q, ROW_AW'(req.row_select));
	assign rd_in_range = (CNT_W'(req.row_select) < count_q)
		&& (COL_W'(req.col_select) < cols_q);
	assign start_clear = (count_q != '0) && ((nc_q != cols_q) || (x_q < epoch_q)
		|| ((x_q - epoch_q) <= newest_q));
	assign retire_go  = (count_q > CNT_W'(MIN_ROWS))
		&& (({1'b0, oldest_rel_q} + {1'b0, window_span_q}) < {1'b0, newest_q});
	assign span       = high_q - low_q;
	assign prod       = PROD_W'(span) * PROD_W'(div_quo);
	assign guess_next = {low_q, {FRAC_W{1'b0}}} + POS_W'(prod >> FRAC_W);
	assign guess_rnd  = {1'b0, guess_q} + (POS_W + 1)'(1 << (FRAC_W - 1));
	assign gi_raw     = guess_rnd[POS_W:FRAC_W];
	assign rsp_free   = !rsp_valid_q || rsp.ready;
	assign div_start  = (state_q == ST_FCHK) && (xr_q > low_v_q) && (xr_q < high_v_q);

	always_comb begin
		gi_next = gi_raw[ROW_AW-1:0];
		if (gi_raw <= {1'b0, low_q}) begin
			gi_next = low_q + 1'b1;
		end
		if (gi_raw >= {1'b0, high_q}) begin
			gi_next = high_q - 1'b1;
		end
	end

	always_comb begin
		t_we    = (state_q == ST_WTIME);
		t_waddr = wr_row;
		t_wdata = x_q - epoch_q;
		v_we    = (state_q == ST_COL) && (pend_q < cols_q);
		v_waddr = VAW'(VAW'(wr_row) * VAW'(MAX_COLS) + VAW'(pend_q));
		v_raddr = VAW'(VAW'(rd_row) * VAW'(MAX_COLS) + VAW'(req.col_select));
		case (state_q)
			ST_IDLE:   t_raddr = rd_row;
			ST_FISSUE: t_raddr = phys_row(oldest_q, gi_next);
			default:   t_raddr = oldest_inc;
		endcase
	end

	twtb_ram #(.WIDTH(TIME_W), .DEPTH(MAX_ROWS)) u_time_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	twtb_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ROWS * MAX_COLS)) u_value_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (y_q),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	twtb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (xr_q - low_v_q),
		.den    (high_v_q - low_v_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			window_span_q <= '0;
			oldest_q      <= '0;
			count_q       <= '0;
			cols_q        <= '0;
			pend_q        <= '0;
			epoch_q       <= '0;
			newest_q      <= '0;
			oldest_rel_q  <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_span_q <= cfg_wdata;
			end
			if (rsp_valid_q && rsp.ready && state_q != ST_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						x_q        <= req.x_value;
						y_q        <= req.y_value;
						nc_q       <= nc_clamp;
						res_ok_q   <= (req.command == CMD_FIND) && (count_q != '0)
							&& (req.x_value < epoch_q);
						res_time_q <= '0;
						res_val_q  <= '0;
						res_pos_q  <= '0;
						case (req.command)
							CMD_START:  state_q <= ST_START;
							CMD_COLUMN: state_q <= ST_COL;
							CMD_FIND: begin
								xr_q     <= req.x_value - epoch_q;
								low_q    <= '0;
								high_q   <= ROW_AW'(count_q - 1'b1);
								low_v_q  <= oldest_rel_q;
								high_v_q <= newest_q;
								if (count_q == '0) begin
									state_q <= ST_FIN;
								end else if (req.x_value < epoch_q) begin
									state_q <= ST_FIN;
								end else begin
									state_q <= ST_FCHK;
								end
							end
							CMD_READ: begin
								state_q <= rd_in_range ? ST_RDW : ST_FIN;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_START: begin
					if (start_clear || count_q == '0) begin
						count_q      <= '0;
						oldest_q     <= '0;
						epoch_q      <= x_q;
						newest_q     <= '0;
						oldest_rel_q <= '0;
					end
					cols_q  <= nc_q;
					pend_q  <= '0;
					state_q <= ST_FULL;
				end
				ST_FULL: begin
					if (count_q == CNT_W'(MAX_ROWS)) begin
						oldest_q <= oldest_inc;
						count_q  <= count_q - 1'b1;
						state_q  <= ST_FULLW;
					end else begin
						state_q <= ST_WTIME;
					end
				end
				ST_FULLW: begin
					oldest_rel_q <= t_rdata;
					state_q      <= ST_WTIME;
				end
				ST_WTIME: begin
					cur_rel_q <= t_wdata;
					res_ok_q  <= 1'b1;
					state_q   <= (cols_q == '0) ? ST_COMPLETE : ST_FIN;
				end
				ST_COL: begin
					if (pend_q < cols_q) begin
						pend_q   <= pend_q + 1'b1;
						res_ok_q <= 1'b1;
						state_q  <= (pend_q + 1'b1 == cols_q) ? ST_COMPLETE : ST_FIN;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_COMPLETE: begin
					newest_q <= cur_rel_q;
					count_q  <= count_q + 1'b1;
					pend_q   <= cols_q;
					state_q  <= ST_RETIRE;
				end
				ST_RETIRE: begin
					if (retire_go) begin
						oldest_q <= oldest_inc;
						count_q  <= count_q - 1'b1;
						state_q  <= ST_RETW;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_RETW: begin
					oldest_rel_q <= t_rdata;
					state_q      <= ST_RETIRE;
				end
				ST_FCHK: begin
					if (xr_q <= low_v_q) begin
						res_ok_q  <= 1'b1;
						res_pos_q <= {low_q, {FRAC_W{1'b0}}};
						state_q   <= ST_FIN;
					end else if (xr_q >= high_v_q) begin
						res_ok_q  <= 1'b1;
						res_pos_q <= {high_q, {FRAC_W{1'b0}}};
						state_q   <= ST_FIN;
					end else begin
						state_q <= ST_FDIV;
					end
				end
				ST_FDIV: begin
					if (div_done) begin
						state_q <= ST_FGUESS;
					end
				end
				ST_FGUESS: begin
					guess_q <= guess_next;
					if (span <= ROW_AW'(1)) begin
						res_ok_q  <= 1'b1;
						res_pos_q <= guess_next;
						state_q   <= ST_FIN;
					end else begin
						state_q <= ST_FISSUE;
					end
				end
				ST_FISSUE: begin
					gi_q    <= gi_next;
					state_q <= ST_FPROBE;
				end
				ST_FPROBE: begin
					if (t_rdata == xr_q) begin
						res_ok_q  <= 1'b1;
						res_pos_q <= {gi_q, {FRAC_W{1'b0}}};
						state_q   <= ST_FIN;
					end else if (xr_q < t_rdata) begin
						high_q   <= gi_q;
						high_v_q <= t_rdata;
						state_q  <= ST_FCHK;
					end else begin
						low_q   <= gi_q;
						low_v_q <= t_rdata;
						state_q <= ST_FCHK;
					end
				end
				ST_RDW: begin
					res_ok_q   <= 1'b1;
					res_time_q <= t_rdata + epoch_q;
					res_val_q  <= v_rdata;
					state_q    <= ST_FIN;
				end
				ST_FIN: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						rsp_ok_q    <= res_ok_q;
						rsp_time_q  <= res_time_q;
						rsp_val_q   <= res_val_q;
						rsp_pos_q   <= res_pos_q;
						rsp_rows_q  <= HOLD_W'(count_q);
						rsp_cols_q  <= NCOL_W'(cols_q);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.ok           = rsp_ok_q;
	assign rsp.time_out     = rsp_time_q;
	assign rsp.value_out    = rsp_val_q;
	assign rsp.row_position = rsp_pos_q;
	assign rsp.rows_held    = rsp_rows_q;
	assign rsp.cols_held    = rsp_cols_q;
endmodule

// ----- rtl/twtb_checker.sv -----
// port level checks of the trend buffer and their binding
module twtb_checker import twtb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  logic              rsp_ok,
	input  logic [TIME_W-1:0] rsp_time,
	input  logic [VAL_W-1:0]  rsp_value,
	input  logic [POS_W-1:0]  rsp_pos,
	input  logic [HOLD_W-1:0] rsp_rows,
	input  logic [NCOL_W-1:0] rsp_cols
);
	// a result stays offered until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// no result during reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("result offered in reset");

	// a failed request carries zero payload
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> rsp_time == '0 && rsp_value == '0 && rsp_pos == '0)
		else $error("failed request with nonzero payload");

	// occupancy within bounds
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_rows <= HOLD_W'(MAX_ROWS) && rsp_cols <= NCOL_W'(MAX_COLS))
		else $error("occupancy out of range");
endmodule

bind time_window_trend_buffer_top twtb_checker u_twtb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_ok    (rsp.ok),
	.rsp_time  (rsp.time_out),
	.rsp_value (rsp.value_out),
	.rsp_pos   (rsp.row_position),
	.rsp_rows  (rsp.rows_held),
	.rsp_cols  (rsp.cols_held)
);
